// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, masked while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/cmrl_pkg.sv -----
package cmrl_pkg;

   localparam int unsigned MAX_WIDTH  = 2048;
   localparam int unsigned MAX_HEIGHT = 2048;
   localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned KEY_W       = 24;
   localparam int unsigned TOL_W       = 32;
   localparam int unsigned SIZE_W      = 12;
   localparam int unsigned RUN_W       = 12;
   localparam int unsigned COUNT_W     = 23;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned NUM_CHAN    = 3;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2048);

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = QUEUE_PTR_W + 1;
   localparam int unsigned RESULT_DEPTH = 2;
   localparam int unsigned RES_PTR_W    = $clog2(RESULT_DEPTH);
   localparam int unsigned RES_CNT_W    = RES_PTR_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_COLOR    = 2'd0,
      CSR_TOLERANCE    = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } cmrl_csr_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_color;
      logic [TOL_W-1:0]  tolerance;
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
   } cmrl_cfg_type;

   typedef struct packed {
      logic             hit;
      logic             first_row;
      logic             row_start;
      logic             frame_end;
      logic [COL_W-1:0] col;
   } cmrl_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
      logic [RUN_W-1:0]   longest_row_run;
      logic [RUN_W-1:0]   longest_column_run;
   } cmrl_result_type;

   // index of the last column or row for a configured size
   function automatic logic [31:0] last_index(logic [SIZE_W-1:0] size, int unsigned maxv);
      logic [31:0] result;
      if (size == '0) begin
         result = '0;
      end else if (32'(size) > maxv) begin
         result = maxv - 1;
      end else begin
         result = 32'(size) - 32'd1;
      end
      return result;
   endfunction

   function automatic logic pixel_match(logic [PIXEL_W-1:0] pixel,
                                        logic [KEY_W-1:0] key,
                                        logic [TOL_W-1:0] tol);
      logic [CHAN_W:0] v;
      logic [CHAN_W:0] c;
      logic [CHAN_W:0] d;
      logic            ok;
      ok = 1'b1;
      for (int i = 0; i < NUM_CHAN; i++) begin
         v = {1'b0, pixel[i*CHAN_W +: CHAN_W]};
         c = {1'b0, key[i*CHAN_W +: CHAN_W]};
         d = {1'b0, tol[i*CHAN_W +: CHAN_W]};
         if ((v + d) < c || v > (c + d)) begin
            ok = 1'b0;
         end
      end
      if (tol == '0 || tol[TOL_W-1]) begin
         ok = (pixel[KEY_W-1:0] == key);
      end
      return ok;
   endfunction

endpackage

// ----- rtl/cmrl_front.sv -----
module cmrl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  cmrl_pkg::cmrl_cfg_type cfg,
   input  logic                   push,
   input  logic                   queue_full,
   input  logic [cmrl_pkg::PIXEL_W-1:0] pixel,
   output logic                   item_valid,
   output cmrl_pkg::cmrl_item_type item
);

   logic [cmrl_pkg::COL_W-1:0] col_pos_ff;
   logic [cmrl_pkg::COL_W-1:0] col_pos_in;
   logic [cmrl_pkg::ROW_W-1:0] row_pos_ff;
   logic [cmrl_pkg::ROW_W-1:0] row_pos_in;
   logic [cmrl_pkg::COL_W-1:0] col_last;
   logic [cmrl_pkg::ROW_W-1:0] row_last;
   logic                       last_col;
   logic                       last_row;

   assign col_last = cmrl_pkg::COL_W'(cmrl_pkg::last_index(cfg.frame_width,
                                                            cmrl_pkg::MAX_WIDTH));
   assign row_last = cmrl_pkg::ROW_W'(cmrl_pkg::last_index(cfg.frame_height,
                                                            cmrl_pkg::MAX_HEIGHT));
   assign last_col = (col_pos_ff >= col_last);
   assign last_row = (row_pos_ff >= row_last);

   assign item_valid     = push && !queue_full;
   assign item.hit       = cmrl_pkg::pixel_match(pixel, cfg.key_color, cfg.tolerance);
   assign item.first_row = (row_pos_ff == '0);
   assign item.row_start = (col_pos_ff == '0);
   assign item.frame_end = last_col && last_row;
   assign item.col       = col_pos_ff;

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (item_valid) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

endmodule

// ----- rtl/cmrl_item_queue.sv -----
module cmrl_item_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  cmrl_pkg::cmrl_item_type wr_item,
   output logic                    full,
   input  logic                    rd_en,
   output logic                    rd_valid,
   output cmrl_pkg::cmrl_item_type rd_item
);

   cmrl_pkg::cmrl_item_type           slot_ff [cmrl_pkg::QUEUE_DEPTH];
   logic [cmrl_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [cmrl_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [cmrl_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [cmrl_pkg::QUEUE_CNT_W-1:0]  count_in;
   logic                              do_wr;
   logic                              do_rd;

   assign full     = (count_ff == cmrl_pkg::QUEUE_CNT_W'(cmrl_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/cmrl_back.sv -----
module cmrl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  cmrl_pkg::cmrl_item_type   q_item,
   output logic                      q_pop,
   output logic                      empty,
   input  logic                      pop,
   output cmrl_pkg::cmrl_result_type result
);

   localparam int unsigned RUN_W   = cmrl_pkg::RUN_W;
   localparam int unsigned COUNT_W = cmrl_pkg::COUNT_W;

   logic [RUN_W-1:0] col_mem [cmrl_pkg::MAX_WIDTH];
   logic [RUN_W-1:0] rd_data_ff;

   // execute stage
   logic                    e_valid_ff;
   cmrl_pkg::cmrl_item_type e_item_ff;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic [RUN_W-1:0]        fwd_data_ff;

   logic [RUN_W-1:0]   row_run_ff;
   logic [RUN_W-1:0]   row_run_in;
   logic [RUN_W-1:0]   best_row_ff;
   logic [RUN_W-1:0]   best_row_in;
   logic [RUN_W-1:0]   best_col_ff;
   logic [RUN_W-1:0]   best_col_in;
   logic [COUNT_W-1:0] matches_ff;
   logic [COUNT_W-1:0] matches_in;

   logic [RUN_W-1:0]   row_base;
   logic [RUN_W-1:0]   row_new;
   logic [RUN_W-1:0]   col_prev;
   logic [RUN_W-1:0]   col_new;
   logic [COUNT_W-1:0] match_new;
   logic [RUN_W-1:0]   best_row_new;
   logic [RUN_W-1:0]   best_col_new;

   // result queue
   cmrl_pkg::cmrl_result_type        res_slot_ff [cmrl_pkg::RESULT_DEPTH];
   logic [cmrl_pkg::RES_PTR_W-1:0]   res_wr_ptr_ff;
   logic [cmrl_pkg::RES_PTR_W-1:0]   res_rd_ptr_ff;
   logic [cmrl_pkg::RES_CNT_W-1:0]   res_count_ff;
   logic [cmrl_pkg::RES_CNT_W-1:0]   res_count_in;
   logic [cmrl_pkg::RES_CNT_W-1:0]   res_pending;
   logic                             res_push;
   logic                             res_pop;

   assign res_push    = e_valid_ff && e_item_ff.frame_end;
   assign res_pending = res_count_ff + cmrl_pkg::RES_CNT_W'(res_push);
   assign q_pop       = q_valid &&
                        (res_pending < cmrl_pkg::RES_CNT_W'(cmrl_pkg::RESULT_DEPTH));
   // same column read while the item ahead writes it
   assign fwd_in      = e_valid_ff && (e_item_ff.col == q_item.col);

   always_comb begin
      row_base  = e_item_ff.row_start ? '0 : row_run_ff;
      col_prev  = e_item_ff.first_row ? '0 : (fwd_ff ? fwd_data_ff : rd_data_ff);
      row_new   = '0;
      col_new   = '0;
      match_new = matches_ff;
      if (e_item_ff.hit) begin
         row_new   = (row_base == cmrl_pkg::RUN_MAX) ? row_base : row_base + 1'b1;
         col_new   = (col_prev == cmrl_pkg::RUN_MAX) ? col_prev : col_prev + 1'b1;
         match_new = (matches_ff == cmrl_pkg::COUNT_MAX) ? matches_ff
                                                         : matches_ff + 1'b1;
      end
      best_row_new = (row_new > best_row_ff) ? row_new : best_row_ff;
      best_col_new = (col_new > best_col_ff) ? col_new : best_col_ff;
   end

   always_comb begin
      row_run_in  = row_run_ff;
      best_row_in = best_row_ff;
      best_col_in = best_col_ff;
      matches_in  = matches_ff;
      if (e_valid_ff) begin
         if (e_item_ff.frame_end) begin
            row_run_in  = '0;
            best_row_in = '0;
            best_col_in = '0;
            matches_in  = '0;
         end else begin
            row_run_in  = row_new;
            best_row_in = best_row_new;
            best_col_in = best_col_new;
            matches_in  = match_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff  <= 1'b0;
         row_run_ff  <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
         matches_ff  <= '0;
      end else begin
         e_valid_ff  <= q_pop;
         row_run_ff  <= row_run_in;
         best_row_ff <= best_row_in;
         best_col_ff <= best_col_in;
         matches_ff  <= matches_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_item_ff   <= q_item;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= col_new;
         rd_data_ff  <= col_mem[q_item.col];
      end
      if (e_valid_ff) begin
         col_mem[e_item_ff.col] <= col_new;
      end
   end

   // result queue
   assign empty   = (res_count_ff == '0);
   assign res_pop = pop && !empty;
   assign result  = res_slot_ff[res_rd_ptr_ff];

   always_comb begin
      res_count_in = res_count_ff;
      if (res_push && !res_pop) begin
         res_count_in = res_count_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         res_count_in = res_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ptr_ff <= '0;
         res_rd_ptr_ff <= '0;
         res_count_ff  <= '0;
      end else begin
         res_count_ff <= res_count_in;
         if (res_push) begin
            res_wr_ptr_ff <= res_wr_ptr_ff + 1'b1;
         end
         if (res_pop) begin
            res_rd_ptr_ff <= res_rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_slot_ff[res_wr_ptr_ff] <= '{match_count:        match_new,
                                         longest_row_run:    best_row_new,
                                         longest_column_run: best_col_new};
      end
   end

endmodule

// ----- rtl/color_match_run_length_stats_core.sv -----
// Color-key run-length statistics. Pixels are pushed in raster order over a frame of
// frame_width by frame_height (0 reads as 1, sizes above 2048 as 2048); each is compared
// with key_color, exactly or within the per-channel tolerance bytes when tolerance is
// nonzero with bit 31 clear. One request per clock is sustained while full is low: the
// front stage classifies a pixel and tracks its position as it is pushed, a four-entry
// queue feeds the back stage, which reads the per-column run from a 2048 x 12 line store
// into a register and writes it back in the cycle after, with a bypass when consecutive
// pixels share a column. At the last pixel of a frame one result (match count, longest
// row run, longest column run) enters the two-entry result queue, and the
// frame counters clear. The line store needs no clearing pass: the first row never reads
// it. Configuration should be written only between pixels with the block drained.
`include "assert_macros.svh"

module color_match_run_length_stats_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [cmrl_pkg::PIXEL_W-1:0]        req_pixel,
   output logic                                empty,
   input  logic                                pop,
   output logic [cmrl_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [cmrl_pkg::RUN_W-1:0]          rsp_longest_row_run,
   output logic [cmrl_pkg::RUN_W-1:0]          rsp_longest_column_run,
   input  logic                                csr_we,
   input  logic [cmrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cmrl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cmrl_pkg::cmrl_cfg_type    cfg_ff;
   cmrl_pkg::cmrl_item_type   front_item;
   logic                      front_valid;
   cmrl_pkg::cmrl_item_type   q_item;
   logic                      q_valid;
   logic                      q_pop;
   cmrl_pkg::cmrl_result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_color    <= '0;
         cfg_ff.tolerance    <= '0;
         cfg_ff.frame_width  <= cmrl_pkg::SIZE_RESET;
         cfg_ff.frame_height <= cmrl_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (cmrl_pkg::cmrl_csr_type'(csr_index))
            cmrl_pkg::CSR_KEY_COLOR: begin
               cfg_ff.key_color <= csr_wdata[cmrl_pkg::KEY_W-1:0];
            end
            cmrl_pkg::CSR_TOLERANCE: begin
               cfg_ff.tolerance <= csr_wdata[cmrl_pkg::TOL_W-1:0];
            end
            cmrl_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.frame_width <= csr_wdata[cmrl_pkg::SIZE_W-1:0];
            end
            cmrl_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= csr_wdata[cmrl_pkg::SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   cmrl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .queue_full (full),
      .pixel      (req_pixel),
      .item_valid (front_valid),
      .item       (front_item)
   );

   cmrl_item_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_item  (front_item),
      .full     (full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_item  (q_item)
   );

   cmrl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .result  (result)
   );

   assign rsp_match_count        = result.match_count;
   assign rsp_longest_row_run    = result.longest_row_run;
   assign rsp_longest_column_run = result.longest_column_run;

   `ASSERT_IMPLIES(a_row_run_fits_row, clock, reset, !empty,
      32'(rsp_longest_row_run) <= cmrl_pkg::MAX_WIDTH)
   `ASSERT_IMPLIES(a_count_covers_run, clock, reset, !empty,
      rsp_match_count >= cmrl_pkg::COUNT_W'(rsp_longest_row_run))
   `ASSERT_NEXT(a_reset_drains, clock, 1'b0, reset, empty && !full)

endmodule

// ----- test/color_match_run_length_stats_core_tb.sv -----
module color_match_run_length_stats_core_tb;
   import cmrl_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1925;
   localparam int unsigned QUIET_AFTER  = 1520;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned TALL_SPLIT   = 150;
   localparam int unsigned WIDE_SPLIT   = 300;

   typedef enum bit {ROW_PIXEL, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      cmrl_csr_type    target;
      logic [31:0]     data;
      bit              has_known;
      cmrl_result_type known;
   } script_row_type;

   localparam cmrl_result_type ONE_HIT = '{23'd1, 12'd1, 12'd1};
   localparam cmrl_result_type NO_HIT  = '0;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [PIXEL_W-1:0]     req_pixel;
   logic                   empty;
   logic                   pop;
   logic [COUNT_W-1:0]     rsp_match_count;
   logic [RUN_W-1:0]       rsp_longest_row_run;
   logic [RUN_W-1:0]       rsp_longest_column_run;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // live register copy and frame state of the predictor
   cmrl_cfg_type live_cfg = '{key_color: '0, tolerance: '0,
                              frame_width: SIZE_RESET, frame_height: SIZE_RESET};
   logic [COL_W-1:0]   pos_col     = '0;
   logic [ROW_W-1:0]   pos_row     = '0;
   logic [RUN_W-1:0]   cur_row_run = '0;
   logic [RUN_W-1:0]   best_row    = '0;
   logic [RUN_W-1:0]   best_col    = '0;
   logic [COUNT_W-1:0] match_total = '0;
   logic [RUN_W-1:0]   col_runs [MAX_WIDTH] = '{default: '0};
   bit                 col_seen [MAX_WIDTH] = '{default: 1'b0};

   cmrl_result_type frame_stats_q [$];
   int unsigned     mismatches  = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     sent        = 0;
   bit              quiet_tail  = 1'b0;

   script_row_type script [38] = '{
      '{ROW_REG,   CSR_FRAME_WIDTH,  32'd1,          1'b0, NO_HIT},
      '{ROW_REG,   CSR_FRAME_HEIGHT, 32'd1,          1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b1, ONE_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'hff00_0000,  1'b1, ONE_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'hffff_ffff,  1'b1, NO_HIT},
      '{ROW_REG,   CSR_KEY_COLOR,    32'h00ff_ffff,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'hffff_ffff,  1'b1, ONE_HIT},
      '{ROW_REG,   CSR_FRAME_WIDTH,  32'd0,          1'b0, NO_HIT},
      '{ROW_REG,   CSR_FRAME_HEIGHT, 32'd0,          1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h00ff_fffe,  1'b1, NO_HIT},
      '{ROW_REG,   CSR_KEY_COLOR,    32'h0080_8080,  1'b0, NO_HIT},
      '{ROW_REG,   CSR_TOLERANCE,    32'h0010_2030,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0070_6050,  1'b1, ONE_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h7f90_a0b0,  1'b1, ONE_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0070_604f,  1'b1, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0091_a0b0,  1'b1, NO_HIT},
      '{ROW_REG,   CSR_TOLERANCE,    32'h8030_3030,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0080_8081,  1'b1, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h1280_8080,  1'b1, ONE_HIT},
      '{ROW_REG,   CSR_KEY_COLOR,    32'h00f0_0010,  1'b0, NO_HIT},
      '{ROW_REG,   CSR_TOLERANCE,    32'h0020_2020,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h00ff_0000,  1'b1, ONE_HIT},
      '{ROW_REG,   CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_REG,   CSR_TOLERANCE,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_REG,   CSR_FRAME_WIDTH,  32'd4,          1'b0, NO_HIT},
      '{ROW_REG,   CSR_FRAME_HEIGHT, 32'd3,          1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0100,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h5a00_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'hff00_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0080_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0001,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h0000_0000,  1'b0, NO_HIT},
      '{ROW_PIXEL, CSR_KEY_COLOR,    32'h3c00_0000,  1'b0, NO_HIT}
   };

   color_match_run_length_stats_core u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_pixel              (req_pixel),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_match_count        (rsp_match_count),
      .rsp_longest_row_run    (rsp_longest_row_run),
      .rsp_longest_column_run (rsp_longest_column_run),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
      if (v == '0) begin
         return 1;
      end
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic bit tolerance_mode();
      return live_cfg.tolerance != '0 && !live_cfg.tolerance[TOL_W-1];
   endfunction

   function automatic bit key_hit(logic [PIXEL_W-1:0] value);
      int ch;
      int v;
      int c;
      int d;
      bit ok;
      if (!tolerance_mode()) begin
         return value[KEY_W-1:0] == live_cfg.key_color;
      end
      ok = 1'b1;
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         v = value[CHAN_W*ch +: CHAN_W];
         c = live_cfg.key_color[CHAN_W*ch +: CHAN_W];
         d = live_cfg.tolerance[CHAN_W*ch +: CHAN_W];
         if (v < c - d || v > c + d) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // advances the frame counters by one pixel, returns 1 at the end of a frame
   function automatic bit step_frame_stats(input logic [PIXEL_W-1:0] value,
                                           output cmrl_result_type stats);
      int unsigned w;
      int unsigned h;
      logic [RUN_W-1:0] col_run;
      bit hit;
      bit last_col;
      bit last_row;
      w = eff_size(live_cfg.frame_width, MAX_WIDTH);
      h = eff_size(live_cfg.frame_height, MAX_HEIGHT);
      hit = key_hit(value);
      last_col = pos_col >= w - 1;
      last_row = pos_row >= h - 1;
      stats = '0;
      if (pos_col == '0) begin
         cur_row_run = '0;
      end
      col_run = (pos_row == '0) ? '0 : col_runs[pos_col];
      if (hit) begin
         if (cur_row_run != RUN_MAX) cur_row_run++;
         if (col_run != RUN_MAX) col_run++;
         if (match_total != COUNT_MAX) match_total++;
      end else begin
         cur_row_run = '0;
         col_run = '0;
      end
      col_runs[pos_col] = col_run;
      col_seen[pos_col] = 1'b1;
      if (cur_row_run > best_row) best_row = cur_row_run;
      if (col_run > best_col) best_col = col_run;
      if (last_col) begin
         pos_col = '0;
         if (last_row) begin
            stats.match_count = match_total;
            stats.longest_row_run = best_row;
            stats.longest_column_run = best_col;
            pos_row = '0;
            cur_row_run = '0;
            best_row = '0;
            best_col = '0;
            match_total = '0;
            return 1'b1;
         end
         pos_row++;
      end else begin
         pos_col++;
      end
      return 1'b0;
   endfunction

   function automatic bit cols_ready(int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++) begin
         if (!col_seen[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] noisy_size(logic [SIZE_W-1:0] v);
      logic [CSR_DATA_W-1:0] r;
      r = $urandom();
      r[SIZE_W-1:0] = v;
      return r;
   endfunction

   function automatic logic [TOL_W-1:0] random_tolerance();
      logic [TOL_W-1:0] t;
      t = $urandom();
      case ($urandom_range(0, 3))
         0: t = '0;
         1: t[TOL_W-1] = 1'b1;
         2: begin
            t[TOL_W-1] = 1'b0;
            t[7:0] = 8'($urandom_range(0, 40));
            t[15:8] = 8'($urandom_range(0, 40));
            t[23:16] = 8'($urandom_range(0, 40));
         end
         default: t[TOL_W-1] = 1'b0;
      endcase
      return t;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(int unsigned hit_pct);
      logic [PIXEL_W-1:0] value;
      int ch;
      int c;
      int d;
      int lo;
      int hi;
      value = $urandom();
      if ($urandom_range(0, 99) < hit_pct) begin
         if (tolerance_mode()) begin
            for (ch = 0; ch < NUM_CHAN; ch++) begin
               c = live_cfg.key_color[CHAN_W*ch +: CHAN_W];
               d = live_cfg.tolerance[CHAN_W*ch +: CHAN_W];
               lo = (c - d < 0) ? 0 : c - d;
               hi = (c + d > 255) ? 255 : c + d;
               value[CHAN_W*ch +: CHAN_W] = 8'($urandom_range(hi, lo));
            end
         end else begin
            value[KEY_W-1:0] = live_cfg.key_color;
         end
      end else if ($urandom_range(0, 2) == 0) begin
         // near miss on one channel
         value[KEY_W-1:0] = live_cfg.key_color;
         ch = $urandom_range(0, NUM_CHAN - 1);
         if (tolerance_mode()) begin
            c = live_cfg.key_color[CHAN_W*ch +: CHAN_W];
            d = live_cfg.tolerance[CHAN_W*ch +: CHAN_W];
            if (c + d < 255 && ($urandom_range(0, 1) == 0 || c - d <= 0)) begin
               value[CHAN_W*ch +: CHAN_W] = 8'(c + d + 1);
            end else if (c - d > 0) begin
               value[CHAN_W*ch +: CHAN_W] = 8'(c - d - 1);
            end
         end else begin
            value[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
         end
      end
      return value;
   endfunction

   task automatic write_reg(input cmrl_csr_type target, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= target;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (target)
         CSR_KEY_COLOR:    live_cfg.key_color = value[KEY_W-1:0];
         CSR_TOLERANCE:    live_cfg.tolerance = value[TOL_W-1:0];
         CSR_FRAME_WIDTH:  live_cfg.frame_width = value[SIZE_W-1:0];
         CSR_FRAME_HEIGHT: live_cfg.frame_height = value[SIZE_W-1:0];
      endcase
      @(posedge clock);
   endtask

   // block drained: no frame result pending and the pipeline empty
   task automatic settle();
      push <= 1'b0;
      while (frame_stats_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] value, input bit use_known,
                             input cmrl_result_type known, output bit produced);
      cmrl_result_type stats;
      req_pixel <= value;
      push <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      produced = step_frame_stats(value, stats);
      if (produced) frame_stats_q.push_back(use_known ? known : stats);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // mid-frame register change; width only grows over columns already written
   task automatic tweak_config();
      cmrl_csr_type pick;
      logic [SIZE_W-1:0] n;
      pick = cmrl_csr_type'($urandom_range(0, 3));
      case (pick)
         CSR_KEY_COLOR: write_reg(pick, $urandom());
         CSR_TOLERANCE: write_reg(pick, random_tolerance());
         CSR_FRAME_WIDTH: begin
            n = SIZE_W'($urandom_range(1, 12));
            if (eff_size(n, MAX_WIDTH) > eff_size(live_cfg.frame_width, MAX_WIDTH) &&
                !cols_ready(eff_size(n, MAX_WIDTH))) begin
               n = live_cfg.frame_width;
            end
            write_reg(pick, noisy_size(n));
         end
         default: write_reg(pick, noisy_size(SIZE_W'($urandom_range(0, 8))));
      endcase
   endtask

   always @(posedge clock) begin
      cmrl_result_type want;
      if (!reset && pop && !empty) begin
         if (frame_stats_q.size() == 0) begin
            $display("%0t: unexpected result count %0d row run %0d column run %0d", $time,
                     rsp_match_count, rsp_longest_row_run, rsp_longest_column_run);
            mismatches++;
         end else begin
            want = frame_stats_q.pop_front();
            if (want.match_count !== rsp_match_count) begin
               $display("%0t: match_count expected %0d actual %0d", $time,
                        want.match_count, rsp_match_count);
               mismatches++;
            end
            if (want.longest_row_run !== rsp_longest_row_run) begin
               $display("%0t: longest_row_run expected %0d actual %0d", $time,
                        want.longest_row_run, rsp_longest_row_run);
               mismatches++;
            end
            if (want.longest_column_run !== rsp_longest_column_run) begin
               $display("%0t: longest_column_run expected %0d actual %0d", $time,
                        want.longest_column_run, rsp_longest_column_run);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      pop <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      int unsigned hit_pct;
      int unsigned frames;
      int unsigned done;
      int unsigned phase;
      bit produced;
      bit wide;
      bit tall;
      reset <= 1'b1;
      push <= 1'b0;
      req_pixel <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_KEY_COLOR;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            settle();
            write_reg(script[i].target, script[i].data);
         end else begin
            send_pixel(script[i].data, script[i].has_known, script[i].known, produced);
         end
      end

      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase++;
         settle();
         wide = (phase == 2);
         tall = (phase == 5);
         hit_pct = $urandom_range(30, 90);
         frames = $urandom_range(1, 4);
         if (wide) begin
            w = '1;
            h = SIZE_W'(1);
            hit_pct = 100;
            frames = 1;
         end else if (tall) begin
            w = SIZE_W'(1);
            h = '1;
            hit_pct = 95;
            frames = 1;
         end else begin
            case ($urandom_range(0, 7))
               0: w = '0;
               1: w = SIZE_W'($urandom_range(13, 64));
               default: w = SIZE_W'($urandom_range(1, 10));
            endcase
            if (w > 12) begin
               h = SIZE_W'($urandom_range(1, 3));
            end else begin
               case ($urandom_range(0, 7))
                  0: h = '0;
                  1: h = SIZE_W'($urandom_range(9, 30));
                  default: h = SIZE_W'($urandom_range(1, 6));
               endcase
            end
         end
         write_reg(CSR_FRAME_WIDTH, noisy_size(w));
         write_reg(CSR_FRAME_HEIGHT, noisy_size(h));
         if (phase <= 2 || $urandom_range(0, 3) != 0) write_reg(CSR_KEY_COLOR, $urandom());
         write_reg(CSR_TOLERANCE, (wide || tall) ? '0 : random_tolerance());

         done = 0;
         while (done < frames) begin
            if (tall && pos_row == TALL_SPLIT && pos_col == '0) begin
               // cut the tall frame short
               settle();
               write_reg(CSR_FRAME_HEIGHT, noisy_size(SIZE_W'(3)));
            end else if (wide && pos_col == WIDE_SPLIT) begin
               // cut the wide frame short
               settle();
               write_reg(CSR_FRAME_WIDTH, noisy_size(SIZE_W'(3)));
            end else if (!tall && !wide && (pos_col != '0 || pos_row != '0) &&
                         $urandom_range(0, 199) == 0) begin
               settle();
               tweak_config();
            end
            send_pixel(pick_pixel(hit_pct), 1'b0, NO_HIT, produced);
            if (produced) done++;
            sent++;
            if (sent >= QUIET_AFTER) quiet_tail = 1'b1;
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cmrl_pkg.sv
rtl/cmrl_front.sv
rtl/cmrl_item_queue.sv
rtl/cmrl_back.sv
rtl/color_match_run_length_stats_core.sv
test/color_match_run_length_stats_core_tb.sv
